// ===== design/etb_pkg.sv =====
// Package for the elapsed timer bank: command codes, gated counter states
// and the fixed field widths. It has no dependencies.
package etb_pkg;

    localparam int MODE_BITS    = 3;
    localparam int SLOT_BITS    = 3;
    localparam int ELAPSED_BITS = 16;
    localparam int VALUE_BITS   = 16;
    localparam int STATE_BITS   = 2;

    // Number of counters the slot field can reach.
    localparam int SLOT_RANGE = 2 ** SLOT_BITS;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK       = 3'd0,
        MODE_READ_FREE  = 3'd1,
        MODE_CLEAR_FREE = 3'd2,
        MODE_READ_GATED = 3'd3,
        MODE_START      = 3'd4,
        MODE_STOP       = 3'd5,
        MODE_PAUSE      = 3'd6,
        MODE_RESUME     = 3'd7
    } mode_t;

    typedef enum logic [STATE_BITS-1:0] {
        GATE_STOPPED = 2'd0,
        GATE_RUNNING = 2'd1,
        GATE_PAUSED  = 2'd2
    } gate_state_t;

endpackage

// ===== design/etb_cmd_if.sv =====
// Command channel of the elapsed timer bank: valid/ready plus one command word.
// Uses field widths from etb_pkg.
interface etb_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [etb_pkg::MODE_BITS-1:0]     mode;
    logic [etb_pkg::SLOT_BITS-1:0]     slot;
    logic [etb_pkg::ELAPSED_BITS-1:0]  elapsed;

    modport source (output valid, output mode, output slot, output elapsed, input ready);
    modport sink   (input valid, input mode, input slot, input elapsed, output ready);
endinterface

// ===== design/etb_rsp_if.sv =====
// Result channel of the elapsed timer bank: valid/ready plus one result word.
// Uses field widths from etb_pkg.
interface etb_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [etb_pkg::VALUE_BITS-1:0]  count_value;
    logic [etb_pkg::STATE_BITS-1:0]  gate_state;

    modport source (output valid, output count_value, output gate_state, input ready);
    modport sink   (input valid, input count_value, input gate_state, output ready);
endinterface

// ===== design/elapsed_timer_bank_top.sv =====
// Elapsed timer bank: free-running and gated elapsed-time counters.
// A command word passes through the command register, then the result register.
// Throughput: one command word per cycle while results are taken; each counter has
// its own adder, so a tick updates every counter in a single pass between those registers.
// Reset (rst_n, asynchronous, active low) clears every counter, stops every gated
// counter and empties both pipeline registers; no clearing pass is needed.
module elapsed_timer_bank_top #(
    parameter int NUM_FREE   = 8,
    parameter int NUM_GATED  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    etb_cmd_if.sink         cmd,
    etb_rsp_if.source       rsp
);

    // Command register stage. A word is held here until the result register
    // can take its result.
    logic                              stage_valid_reg;
    logic                              stage_valid_next;
    etb_pkg::mode_t                    stage_mode_reg;
    logic [etb_pkg::SLOT_BITS-1:0]     stage_slot_reg;
    logic [etb_pkg::ELAPSED_BITS-1:0]  stage_elapsed_reg;

    // Counter banks and gated counter states.
    logic [COUNT_BITS-1:0]  free_reg   [NUM_FREE];
    logic [COUNT_BITS-1:0]  free_next  [NUM_FREE];
    logic [COUNT_BITS-1:0]  gated_reg  [NUM_GATED];
    logic [COUNT_BITS-1:0]  gated_next [NUM_GATED];
    etb_pkg::gate_state_t   gstate_reg  [NUM_GATED];
    etb_pkg::gate_state_t   gstate_next [NUM_GATED];

    // Result register.
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [etb_pkg::VALUE_BITS-1:0]    out_value_reg;
    logic [etb_pkg::VALUE_BITS-1:0]    out_value_next;
    etb_pkg::gate_state_t              out_gate_reg;
    etb_pkg::gate_state_t              out_gate_next;

    logic                    advance;
    logic                    cmd_accept;
    logic                    process;
    logic [NUM_FREE-1:0]     free_sel;
    logic [NUM_GATED-1:0]    gated_sel;
    logic [COUNT_BITS-1:0]   elapsed_ext;
    logic [COUNT_BITS-1:0]   read_count;

    // The result register frees up when it is empty or being drained; the command stage
    // then moves its word on; while results drain, one word per cycle goes through.
    assign advance    = !out_valid_reg || rsp.ready;
    assign cmd.ready  = !stage_valid_reg || advance;
    assign cmd_accept = cmd.valid && cmd.ready;
    assign process    = stage_valid_reg && advance;

    // The elapsed count wraps modulo 2^COUNT_BITS, so truncation is correct
    // for narrow counters and zero extension for wide ones.
    assign elapsed_ext = COUNT_BITS'(stage_elapsed_reg);

    // Slot decode. Counters beyond the reach of the slot field are never
    // addressed, and a slot beyond the bank size selects nothing.
    always_comb
    begin
        for (int i = 0; i < NUM_FREE; i++)
        begin
            free_sel[i] = (i < etb_pkg::SLOT_RANGE)
                       && (int'(stage_slot_reg) == i);
        end
        for (int i = 0; i < NUM_GATED; i++)
        begin
            gated_sel[i] = (i < etb_pkg::SLOT_RANGE)
                        && (int'(stage_slot_reg) == i);
        end
    end

    // Counter update and result formation for the word in the command stage.
    always_comb
    begin
        for (int i = 0; i < NUM_FREE; i++)
        begin
            free_next[i] = free_reg[i];
        end
        for (int i = 0; i < NUM_GATED; i++)
        begin
            gated_next[i]  = gated_reg[i];
            gstate_next[i] = gstate_reg[i];
        end
        read_count = '0;

        unique case (stage_mode_reg)
            etb_pkg::MODE_TICK:
            begin
                for (int i = 0; i < NUM_FREE; i++)
                begin
                    free_next[i] = free_reg[i] + elapsed_ext;
                end
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gstate_reg[i] == etb_pkg::GATE_RUNNING)
                    begin
                        gated_next[i] = gated_reg[i] + elapsed_ext;
                    end
                end
            end
            etb_pkg::MODE_READ_FREE:
            begin
                for (int i = 0; i < NUM_FREE; i++)
                begin
                    if (free_sel[i])
                    begin
                        read_count = free_reg[i];
                    end
                end
            end
            etb_pkg::MODE_CLEAR_FREE:
            begin
                for (int i = 0; i < NUM_FREE; i++)
                begin
                    if (free_sel[i])
                    begin
                        free_next[i] = '0;
                    end
                end
            end
            etb_pkg::MODE_READ_GATED:
            begin
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gated_sel[i])
                    begin
                        read_count = gated_reg[i];
                    end
                end
            end
            etb_pkg::MODE_START:
            begin
                // Start only takes effect on a stopped counter.
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gated_sel[i] && gstate_reg[i] == etb_pkg::GATE_STOPPED)
                    begin
                        gated_next[i]  = '0;
                        gstate_next[i] = etb_pkg::GATE_RUNNING;
                    end
                end
            end
            etb_pkg::MODE_STOP:
            begin
                // Stop keeps the count.
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gated_sel[i])
                    begin
                        gstate_next[i] = etb_pkg::GATE_STOPPED;
                    end
                end
            end
            etb_pkg::MODE_PAUSE:
            begin
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gated_sel[i] && gstate_reg[i] == etb_pkg::GATE_RUNNING)
                    begin
                        gstate_next[i] = etb_pkg::GATE_PAUSED;
                    end
                end
            end
            etb_pkg::MODE_RESUME:
            begin
                for (int i = 0; i < NUM_GATED; i++)
                begin
                    if (gated_sel[i] && gstate_reg[i] == etb_pkg::GATE_PAUSED)
                    begin
                        gstate_next[i] = etb_pkg::GATE_RUNNING;
                    end
                end
            end
        endcase

        // Gated modes report the addressed counter's state after the step;
        // the free modes and a slot outside the gated bank report stopped.
        out_gate_next = etb_pkg::GATE_STOPPED;
        if (stage_mode_reg != etb_pkg::MODE_TICK
            && stage_mode_reg != etb_pkg::MODE_READ_FREE
            && stage_mode_reg != etb_pkg::MODE_CLEAR_FREE)
        begin
            for (int i = 0; i < NUM_GATED; i++)
            begin
                if (gated_sel[i])
                begin
                    out_gate_next = gstate_next[i];
                end
            end
        end
        out_value_next = etb_pkg::VALUE_BITS'(read_count);
    end

    always_comb
    begin
        if (cmd_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and counter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_FREE; i++)
            begin
                free_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_GATED; i++)
            begin
                gated_reg[i]  <= '0;
                gstate_reg[i] <= etb_pkg::GATE_STOPPED;
            end
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (process)
            begin
                free_reg   <= free_next;
                gated_reg  <= gated_next;
                gstate_reg <= gstate_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            stage_mode_reg    <= etb_pkg::mode_t'(cmd.mode);
            stage_slot_reg    <= cmd.slot;
            stage_elapsed_reg <= cmd.elapsed;
        end
        if (process)
        begin
            out_value_reg <= out_value_next;
            out_gate_reg  <= out_gate_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.count_value = out_value_reg;
    assign rsp.gate_state  = out_gate_reg;

endmodule

// ===== design/etb_checker.sv =====
// Port-level checks for the elapsed timer bank, bound to elapsed_timer_bank_top.
// Depends on the top level's command and result interface ports.
module etb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] rsp_count_value,
    input logic [1:0]  rsp_gate_state
);

    // Words accepted but not yet delivered; the design holds at most two.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       cmd_fire;
    logic       rsp_fire;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_fire && !cmd_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_value)
                                    && $stable(rsp_gate_state))
        else $error("result word changed while stalled");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two words in flight");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> !rsp_valid)
        else $error("result word with no command outstanding");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("command refused while result side is empty");

endmodule

bind elapsed_timer_bank_top etb_checker u_etb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_count_value (rsp.count_value),
    .rsp_gate_state  (rsp.gate_state)
);

// ===== dv/elapsed_timer_bank_top_tb.sv =====
// Self-checking testbench for elapsed_timer_bank_top: drives command words, predicts
// every result word from its own model of both counter banks and checks them in order.
// Depends on etb_pkg, etb_cmd_if, etb_rsp_if and the elapsed_timer_bank_top RTL.
module elapsed_timer_bank_top_tb;

    // The block is built with its default sizes; the model uses the same ones.
    localparam int NUM_FREE    = 8;
    localparam int NUM_GATED   = 8;
    localparam int COUNT_BITS  = 16;

    // A command word goes through the command register and then the result register.
    localparam int PIPE_DEPTH  = 2;

    // Long hold-off on the result side, in cycles, used to back the block up.
    localparam int HOLD_CYCLES = 60;

    // The slowest correct run is roughly 640 words, each waiting out the longest
    // send gap and result stall plus the pipeline, and one long hold; the limit
    // sits far above the length of such a run.
    localparam int CYCLE_LIMIT = 200000;

    // Mismatch lines beyond this many are counted but not printed.
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [etb_pkg::VALUE_BITS-1:0] count_value;
        etb_pkg::gate_state_t           gate_state;
    } timer_result_t;

    logic clk = 1'b0;
    logic rst_n;

    etb_cmd_if cmd_ch ();
    etb_rsp_if rsp_ch ();

    elapsed_timer_bank_top #(
        .NUM_FREE   (NUM_FREE),
        .NUM_GATED  (NUM_GATED),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Our own copy of the counter banks. Every counter is zero and every gated
    // counter is stopped after reset, which is where these start.
    logic [COUNT_BITS-1:0] free_shadow  [NUM_FREE]  = '{default: '0};
    logic [COUNT_BITS-1:0] gated_shadow [NUM_GATED] = '{default: '0};
    etb_pkg::gate_state_t  gate_shadow  [NUM_GATED] = '{default: etb_pkg::GATE_STOPPED};

    // Result words predicted for accepted command words, oldest first.
    timer_result_t expected_results [$];

    int  cycle_count     = 0;
    int  words_sent      = 0;
    int  ticks_sent      = 0;
    int  results_checked = 0;
    int  mismatch_count  = 0;
    int  ready_gap_left  = 0;

    // Both are written with nonblocking assignments at the clock edge, so every
    // process that samples them at an edge sees the same value.
    bit  idling_on;
    bit  result_hold;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Free-running cycle count and the watchdog that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d result words outstanding.",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Applies one command word to the shadow banks and returns the result word
    // the block should give for it.
    function automatic timer_result_t advance_timers(
        etb_pkg::mode_t                    mode,
        logic [etb_pkg::SLOT_BITS-1:0]     slot,
        logic [etb_pkg::ELAPSED_BITS-1:0]  elapsed
    );
        timer_result_t res;
        res.count_value = '0;
        res.gate_state  = etb_pkg::GATE_STOPPED;
        case (mode)
            etb_pkg::MODE_TICK:
            begin
                // Every free counter and every running gated counter moves on;
                // the sum wraps at the counter width.
                for (int i = 0; i < NUM_FREE; i++)
                    free_shadow[i] = free_shadow[i] + COUNT_BITS'(elapsed);
                for (int i = 0; i < NUM_GATED; i++)
                    if (gate_shadow[i] == etb_pkg::GATE_RUNNING)
                        gated_shadow[i] = gated_shadow[i] + COUNT_BITS'(elapsed);
            end
            etb_pkg::MODE_READ_FREE:
            begin
                if (int'(slot) < NUM_FREE)
                    res.count_value = etb_pkg::VALUE_BITS'(free_shadow[slot]);
            end
            etb_pkg::MODE_CLEAR_FREE:
            begin
                if (int'(slot) < NUM_FREE)
                    free_shadow[slot] = '0;
            end
            default:
            begin
                // Gated commands report the state of the addressed counter after
                // the command has taken effect.
                if (int'(slot) < NUM_GATED)
                begin
                    case (mode)
                        etb_pkg::MODE_READ_GATED:
                            res.count_value = etb_pkg::VALUE_BITS'(gated_shadow[slot]);
                        etb_pkg::MODE_START:
                            if (gate_shadow[slot] == etb_pkg::GATE_STOPPED)
                            begin
                                gated_shadow[slot] = '0;
                                gate_shadow[slot]  = etb_pkg::GATE_RUNNING;
                            end
                        etb_pkg::MODE_STOP:
                            gate_shadow[slot] = etb_pkg::GATE_STOPPED;
                        etb_pkg::MODE_PAUSE:
                            if (gate_shadow[slot] == etb_pkg::GATE_RUNNING)
                                gate_shadow[slot] = etb_pkg::GATE_PAUSED;
                        default:
                            if (gate_shadow[slot] == etb_pkg::GATE_PAUSED)
                                gate_shadow[slot] = etb_pkg::GATE_RUNNING;
                    endcase
                    res.gate_state = gate_shadow[slot];
                end
            end
        endcase
        return res;
    endfunction

    // Elapsed counts lean toward the corners: zero, the full 16-bit value and
    // small steps, with fully random values for the rest.
    function automatic logic [etb_pkg::ELAPSED_BITS-1:0] pick_elapsed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return etb_pkg::ELAPSED_BITS'($urandom_range(1, 64));
            default: return etb_pkg::ELAPSED_BITS'($urandom);
        endcase
    endfunction

    // Offers one command word, waits for the edge that accepts it, then records
    // the predicted result. Valid stays high into the next word unless the
    // sender takes a random breather here.
    task automatic send_cmd(etb_pkg::mode_t mode, logic [etb_pkg::SLOT_BITS-1:0] slot,
                            logic [etb_pkg::ELAPSED_BITS-1:0] elapsed);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= mode;
        cmd_ch.slot    <= slot;
        cmd_ch.elapsed <= elapsed;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        expected_results.push_back(advance_timers(mode, slot, elapsed));
        words_sent++;
        if (mode == etb_pkg::MODE_TICK)
            ticks_sent++;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_random_word();
        send_cmd(etb_pkg::mode_t'($urandom_range(0, 7)), etb_pkg::SLOT_BITS'($urandom),
                 pick_elapsed());
    endtask

    // Result side: ready is low in reset, drops in random bursts while idling is
    // on, and stays low for the whole of a long hold.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (result_hold)
                rsp_ch.ready <= 1'b0;
            else if (!idling_on)
                rsp_ch.ready <= 1'b1;
            else if (ready_gap_left > 0)
            begin
                rsp_ch.ready   <= 1'b0;
                ready_gap_left <= ready_gap_left - 1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready   <= 1'b0;
                ready_gap_left <= $urandom_range(0, 3);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Every accepted result word is matched against the oldest prediction.
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result word with nothing expected: %h state %0d",
                                          rsp_ch.count_value, rsp_ch.gate_state));
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (rsp_ch.count_value !== want.count_value)
                    report_mismatch($sformatf("result %0d count_value %h, expected %h",
                                              results_checked, rsp_ch.count_value,
                                              want.count_value));
                if (rsp_ch.gate_state !== want.gate_state)
                    report_mismatch($sformatf("result %0d gate_state %0d, expected %0d",
                                              results_checked, rsp_ch.gate_state,
                                              want.gate_state));
            end
        end
    end

    // Free bank: reads from reset, a zero tick, wrap-around past the top of the
    // counter, and a clear that must touch only its own slot.
    task automatic test_free_counters();
        send_cmd(etb_pkg::MODE_READ_FREE, 3'd0, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd0, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd7, 16'hFFFF);
        send_cmd(etb_pkg::MODE_READ_FREE, 3'd7, 16'hFFFF);
        send_cmd(etb_pkg::MODE_TICK, 3'd0, 16'h0001);
        send_cmd(etb_pkg::MODE_READ_FREE, 3'd0, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd5, 16'h1234);
        send_cmd(etb_pkg::MODE_CLEAR_FREE, 3'd5, 16'hFFFF);
        send_cmd(etb_pkg::MODE_READ_FREE, 3'd5, 16'h0000);
        send_cmd(etb_pkg::MODE_READ_FREE, 3'd3, 16'h0000);
    endtask

    // Gated bank: a counter's lifecycle through every state, including the
    // commands that must be ignored (pause or resume while stopped, start while
    // running or paused, resume while running) and stop from each state.
    task automatic test_gated_lifecycle();
        send_cmd(etb_pkg::MODE_READ_GATED, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_PAUSE, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_RESUME, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_START, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_START, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd2, 16'h0100);
        send_cmd(etb_pkg::MODE_PAUSE, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd2, 16'hFFFF);
        send_cmd(etb_pkg::MODE_START, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_RESUME, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_RESUME, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_TICK, 3'd2, 16'h0002);
        send_cmd(etb_pkg::MODE_STOP, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_READ_GATED, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_START, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_PAUSE, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_STOP, 3'd2, 16'h0000);
        send_cmd(etb_pkg::MODE_STOP, 3'd7, 16'h0000);
    endtask

    // Mostly complete timer lifecycles on a random slot with random ticks in
    // between, mixed with fully random words that hit commands out of order.
    // Some timers are left running or paused so later ticks find a mix of states.
    task automatic test_random_traffic(int n);
        int                            base;
        logic [etb_pkg::SLOT_BITS-1:0] slot;
        base = words_sent;
        while (words_sent - base < n)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                slot = etb_pkg::SLOT_BITS'($urandom);
                send_cmd(etb_pkg::MODE_START, slot, etb_pkg::ELAPSED_BITS'($urandom));
                repeat ($urandom_range(1, 3))
                    send_cmd(etb_pkg::MODE_TICK, etb_pkg::SLOT_BITS'($urandom),
                             pick_elapsed());
                if ($urandom_range(0, 3) != 0)
                begin
                    send_cmd(etb_pkg::MODE_PAUSE, slot, etb_pkg::ELAPSED_BITS'($urandom));
                    send_cmd(etb_pkg::MODE_TICK, etb_pkg::SLOT_BITS'($urandom),
                             pick_elapsed());
                    send_cmd(etb_pkg::MODE_READ_GATED, slot,
                             etb_pkg::ELAPSED_BITS'($urandom));
                    send_cmd(etb_pkg::MODE_RESUME, slot, etb_pkg::ELAPSED_BITS'($urandom));
                    send_cmd(etb_pkg::MODE_TICK, etb_pkg::SLOT_BITS'($urandom),
                             pick_elapsed());
                end
                send_cmd(etb_pkg::MODE_READ_GATED, slot, etb_pkg::ELAPSED_BITS'($urandom));
                send_cmd(etb_pkg::MODE_READ_FREE, etb_pkg::SLOT_BITS'($urandom),
                         etb_pkg::ELAPSED_BITS'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send_cmd(etb_pkg::MODE_CLEAR_FREE, etb_pkg::SLOT_BITS'($urandom),
                             etb_pkg::ELAPSED_BITS'($urandom));
                if ($urandom_range(0, 1) == 0)
                    send_cmd(etb_pkg::MODE_STOP, slot, etb_pkg::ELAPSED_BITS'($urandom));
            end
            else
                send_random_word();
        end
    endtask

    // The result side holds off for a long stretch while the sender keeps
    // offering words, so the pipeline fills and the block must stall its input.
    task automatic test_result_backpressure(int n);
        fork
            begin
                result_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_hold <= 1'b0;
            end
            begin
                repeat (n) send_random_word();
            end
        join
    endtask

    // Final stretch with no idling on either side: one word per cycle.
    task automatic test_back_to_back(int n);
        idling_on <= 1'b0;
        repeat (n) send_random_word();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.mode    <= etb_pkg::MODE_TICK;
        cmd_ch.slot    <= '0;
        cmd_ch.elapsed <= '0;
        idling_on      <= 1'b1;
        result_hold    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_free_counters();
        test_gated_lifecycle();
        test_random_traffic(450);
        test_result_backpressure(40);
        test_back_to_back(100);

        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // Anything arriving now would be a spurious result word.
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Covered %0d command words (%0d ticks) with %0d result words checked.",
                 words_sent, ticks_sent, results_checked);
        $display("Included random idling on both sides, a %0d-cycle result hold-off and a %s",
                 HOLD_CYCLES, "full-rate stretch.");
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
